>>> hdl/imu_dr_pkg.sv
// Shared types, constants and register indexes for the IMU dead-reckoning integrator.
`default_nettype none
package imu_dr_pkg;

  localparam int AccW  = 24;
  localparam int QuatW = 16;
  localparam int StW   = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam int DefQueueDepth = 2;

  localparam logic [CfgIdxW-1:0] RegGravX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGravY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGravZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDbLim  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDecay  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTStep  = 3'd5;

  localparam logic [22:0] DbLimReset = 23'd11796;
  localparam logic [15:0] DecayReset = 16'd58982;
  localparam logic [15:0] TStepReset = 16'd3277;

  // One queued sample: body acceleration and quaternion.
  typedef struct packed {
    logic signed [AccW-1:0]  ax;
    logic signed [AccW-1:0]  ay;
    logic signed [AccW-1:0]  az;
    logic signed [QuatW-1:0] qw;
    logic signed [QuatW-1:0] qx;
    logic signed [QuatW-1:0] qy;
    logic signed [QuatW-1:0] qz;
  } imu_sample_t;

endpackage : imu_dr_pkg
`default_nettype wire

>>> hdl/imu_dr_queue.sv
// Short FIFO that decouples sample intake from the integration engine.
`default_nettype none
module imu_dr_queue
  import imu_dr_pkg::*;
#(
  parameter int Depth = DefQueueDepth
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         wr_valid,
  output logic        wr_ready,
  input  imu_sample_t wr_data,
  output logic        rd_valid,
  input  wire         rd_ready,
  output imu_sample_t rd_data
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  imu_sample_t mem_r [Depth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [CntW-1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != CntW'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  // Store incoming item.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(wr_en) - CntW'(rd_en);
    end
  end
endmodule : imu_dr_queue
`default_nettype wire

>>> hdl/imu_dr_engine.sv
// Sequenced rotation, deadband and Euler integration engine with one shared multiplier.
`default_nettype none
module imu_dr_engine
  import imu_dr_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    smp_valid,
  output logic                   smp_ready,
  input  imu_sample_t            smp,
  input  wire signed [AccW-1:0]  grav_x,
  input  wire signed [AccW-1:0]  grav_y,
  input  wire signed [AccW-1:0]  grav_z,
  input  wire [22:0]             db_lim,
  input  wire [15:0]             decay,
  input  wire [15:0]             tstep,
  output logic                   res_valid,
  input  wire                    res_ready,
  output logic signed [AccW-1:0] res_ax,
  output logic signed [AccW-1:0] res_ay,
  output logic signed [AccW-1:0] res_az,
  output logic signed [StW-1:0]  res_vx,
  output logic signed [StW-1:0]  res_vy,
  output logic signed [StW-1:0]  res_vz,
  output logic signed [StW-1:0]  res_px,
  output logic signed [StW-1:0]  res_py,
  output logic signed [StW-1:0]  res_pz
);
  // Phases: T computes u x v (6 products), S computes u x t (6 products),
  // WT forms 3x w*t, ACC forms the rotated vector, then per axis deadband/vel/pos.
  typedef enum logic [2:0] {
    ST_IDLE, ST_T, ST_S, ST_WT, ST_ACC, ST_DEC, ST_VEL, ST_POS
  } state_t;

  state_t state_r;
  logic [2:0] step_r;
  logic [1:0] ax_r;
  imu_sample_t s_r;
  logic signed [40:0] t_r [3];     // Q30 cross product
  logic signed [58:0] sx_r [3];    // Q44 second cross product
  logic signed [60:0] wt_r [3];    // w*t
  logic signed [AccW-1:0] acc_r [3];
  logic signed [StW-1:0] vel_r [3];
  logic signed [StW-1:0] pos_r [3];
  logic signed [StW-1:0] vtmp_r;
  logic out_v_r;

  // Shared multiplier: operands picked by phase, 42 x 19 signed.
  logic signed [41:0] ma;
  logic signed [18:0] mb;
  logic signed [60:0] prod;
  logic signed [40:0] tm;

  function automatic logic signed [AccW-1:0] pick_v(imu_sample_t sm, logic [1:0] i);
    case (i)
      2'd0:    pick_v = sm.ax;
      2'd1:    pick_v = sm.ay;
      default: pick_v = sm.az;
    endcase
  endfunction

  function automatic logic signed [QuatW-1:0] pick_u(imu_sample_t sm, logic [1:0] i);
    case (i)
      2'd0:    pick_u = sm.qx;
      2'd1:    pick_u = sm.qy;
      default: pick_u = sm.qz;
    endcase
  endfunction

  // Cross product term index: step k -> component k/2, first or second term.
  logic [1:0] comp, ia, ib;
  always_comb begin
    comp = step_r[2:1];
    ia = '0;
    ib = '0;
    case (comp)
      2'd0:    begin ia = 2'd1; ib = 2'd2; end
      2'd1:    begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
    if (step_r[0]) begin
      {ia, ib} = {ib, ia};
    end
  end

  logic signed [StW-1:0] vcur;
  logic signed [StW-1:0] vsel;
  always_comb begin
    vcur = vel_r[ax_r];
    vsel = vtmp_r;
    tm = t_r[ib];
    ma = '0;
    mb = '0;
    case (state_r)
      ST_T: begin
        ma = 42'(pick_v(s_r, ib));
        mb = 19'(pick_u(s_r, ia));
      end
      ST_S: begin
        ma = 42'(tm);
        mb = 19'(pick_u(s_r, ia));
      end
      ST_WT: begin
        ma = 42'(t_r[ax_r]);
        mb = 19'(s_r.qw);
      end
      ST_DEC: begin
        ma = 42'(vcur);
        mb = $signed({3'b000, decay});
      end
      ST_VEL: begin
        ma = 42'(acc_r[ax_r]);
        mb = $signed({3'b000, tstep});
      end
      ST_POS: begin
        ma = 42'(vsel);
        mb = $signed({3'b000, tstep});
      end
      default: ;
    endcase
    prod = 61'(ma) * 61'(mb);
  end

  // Rotated vector, rounding, gravity removal, saturation.
  logic signed [63:0] rsum, rrnd, asub;
  logic signed [AccW-1:0] gsel, asat;
  always_comb begin
    case (ax_r)
      2'd0:    gsel = grav_x;
      2'd1:    gsel = grav_y;
      default: gsel = grav_z;
    endcase
    rsum = (64'(pick_v(s_r, ax_r)) <<< 28) + (64'(wt_r[ax_r]) <<< 1)
         + (64'(sx_r[ax_r]) <<< 1);
    rrnd = (rsum + 64'sd134217728) >>> 28;
    asub = rrnd - 64'(gsel);
    if (asub > 64'sd8388607)       asat = 24'sh7fffff;
    else if (asub < -64'sd8388608) asat = 24'sh800000;
    else                           asat = asub[AccW-1:0];
  end

  // Q16 round and 32-bit saturating add.
  logic signed [44:0] prnd;
  logic signed [45:0] vsum, psum;
  logic signed [StW-1:0] vsat, psat;
  logic in_db;
  logic [AccW-1:0] amag;
  always_comb begin
    prnd = 45'((prod + 61'sd32768) >>> 16);
    vsum = 46'(vsel) + 46'(prnd);
    psum = 46'(pos_r[ax_r]) + 46'(prnd);
    vsat = (vsum > 46'sd2147483647) ? 32'sh7fffffff :
           (vsum < -46'sd2147483648) ? 32'sh80000000 : vsum[StW-1:0];
    psat = (psum > 46'sd2147483647) ? 32'sh7fffffff :
           (psum < -46'sd2147483648) ? 32'sh80000000 : psum[StW-1:0];
    amag = acc_r[ax_r][AccW-1] ? AccW'(-acc_r[ax_r]) : acc_r[ax_r];
    in_db = (ax_r != 2'd2) && ({1'b0, amag} < {2'b00, db_lim});
  end

  assign smp_ready = (state_r == ST_IDLE) && !out_v_r;
  assign res_valid = out_v_r;
  assign res_ax = acc_r[0];
  assign res_ay = acc_r[1];
  assign res_az = acc_r[2];
  assign res_vx = vel_r[0];
  assign res_vy = vel_r[1];
  assign res_vz = vel_r[2];
  assign res_px = pos_r[0];
  assign res_py = pos_r[1];
  assign res_pz = pos_r[2];

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ax_r    <= '0;
      out_v_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      if (out_v_r && res_ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (smp_valid && smp_ready) begin
            s_r     <= smp;
            step_r  <= '0;
            state_r <= ST_T;
          end
        end
        ST_T: begin
          if (!step_r[0]) t_r[comp] <= 41'(prod);
          else            t_r[comp] <= t_r[comp] - 41'(prod);
          if (step_r == 3'd5) begin
            step_r  <= '0;
            state_r <= ST_S;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_S: begin
          if (!step_r[0]) sx_r[comp] <= 59'(prod);
          else            sx_r[comp] <= sx_r[comp] - 59'(prod);
          if (step_r == 3'd5) begin
            ax_r    <= '0;
            state_r <= ST_WT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_WT: begin
          wt_r[ax_r] <= prod;
          if (ax_r == 2'd2) begin
            ax_r    <= '0;
            state_r <= ST_ACC;
          end else begin
            ax_r <= ax_r + 1'b1;
          end
        end
        ST_ACC: begin
          acc_r[ax_r] <= asat;
          if (ax_r == 2'd2) begin
            ax_r    <= '0;
            state_r <= ST_DEC;
          end else begin
            ax_r <= ax_r + 1'b1;
          end
        end
        ST_DEC: begin
          // Zero the axis and decay its velocity when inside the deadband.
          if (in_db) begin
            acc_r[ax_r] <= '0;
            vtmp_r      <= prnd[StW-1:0];
          end else begin
            vtmp_r <= vcur;
          end
          state_r <= ST_VEL;
        end
        ST_VEL: begin
          vel_r[ax_r] <= vsat;
          vtmp_r      <= vsat;
          state_r     <= ST_POS;
        end
        ST_POS: begin
          pos_r[ax_r] <= psat;
          if (ax_r == 2'd2) begin
            ax_r    <= '0;
            out_v_r <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= ST_DEC;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule : imu_dr_engine
`default_nettype wire

>>> hdl/imu_dead_reckoning_integrator.sv
// Top level: config registers, intake queue and integration engine.
// An accepted sample is stored in the queue, then read by the engine once it is idle.
// The engine works on one item at a time: the single shared multiplier steps through
//   6+6+3 products, then decay, velocity and position per axis, and the engine holds off
//   the next item until its result is taken.
// Reset (rst_n low, synchronous) clears velocity, position, queue and sets
//   register defaults.
`default_nettype none
module imu_dead_reckoning_integrator
  import imu_dr_pkg::*;
#(
  parameter int QueueDepth = DefQueueDepth
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire [CfgIdxW-1:0]       cfg_index,
  input  wire [CfgDataW-1:0]      cfg_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire signed [AccW-1:0]   in_accel_x,
  input  wire signed [AccW-1:0]   in_accel_y,
  input  wire signed [AccW-1:0]   in_accel_z,
  input  wire signed [QuatW-1:0]  in_quat_w,
  input  wire signed [QuatW-1:0]  in_quat_x,
  input  wire signed [QuatW-1:0]  in_quat_y,
  input  wire signed [QuatW-1:0]  in_quat_z,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [AccW-1:0]  out_world_accel_x,
  output logic signed [AccW-1:0]  out_world_accel_y,
  output logic signed [AccW-1:0]  out_world_accel_z,
  output logic signed [StW-1:0]   out_velocity_x,
  output logic signed [StW-1:0]   out_velocity_y,
  output logic signed [StW-1:0]   out_velocity_z,
  output logic signed [StW-1:0]   out_position_x,
  output logic signed [StW-1:0]   out_position_y,
  output logic signed [StW-1:0]   out_position_z
);
  logic signed [AccW-1:0] grav_x_r, grav_y_r, grav_z_r;
  logic [22:0] db_lim_r;
  logic [15:0] decay_r, tstep_r;
  imu_sample_t in_smp, q_smp;
  logic q_valid, q_ready;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_x_r <= '0;
      grav_y_r <= '0;
      grav_z_r <= '0;
      db_lim_r <= DbLimReset;
      decay_r  <= DecayReset;
      tstep_r  <= TStepReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegGravX: grav_x_r <= cfg_data;
        RegGravY: grav_y_r <= cfg_data;
        RegGravZ: grav_z_r <= cfg_data;
        RegDbLim: db_lim_r <= cfg_data[22:0];
        RegDecay: decay_r  <= cfg_data[15:0];
        RegTStep: tstep_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_smp = '{ax: in_accel_x, ay: in_accel_y, az: in_accel_z,
                    qw: in_quat_w, qx: in_quat_x, qy: in_quat_y, qz: in_quat_z};

  imu_dr_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_smp),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_smp)
  );

  imu_dr_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .smp_valid(q_valid), .smp_ready(q_ready), .smp(q_smp),
    .grav_x(grav_x_r), .grav_y(grav_y_r), .grav_z(grav_z_r),
    .db_lim(db_lim_r), .decay(decay_r), .tstep(tstep_r),
    .res_valid(out_valid), .res_ready(out_ready),
    .res_ax(out_world_accel_x), .res_ay(out_world_accel_y), .res_az(out_world_accel_z),
    .res_vx(out_velocity_x), .res_vy(out_velocity_y), .res_vz(out_velocity_z),
    .res_px(out_position_x), .res_py(out_position_y), .res_pz(out_position_z)
  );

  // Result must not drop before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Engine takes no new sample while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_ready)
    else $error("engine accepted sample with result pending");

  // Stalled result keeps its velocity x and position z values.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_velocity_x) && $stable(out_position_z))
    else $error("result changed while stalled");
endmodule : imu_dead_reckoning_integrator
`default_nettype wire

>>> dv/imu_dead_reckoning_integrator_tb.sv
// Self-checking testbench for the IMU dead-reckoning integrator.
`timescale 1ns / 1ps
`default_nettype none
module imu_dead_reckoning_integrator_tb;
  import imu_dr_pkg::*;

  localparam int DrainCycles = 80;

  typedef struct {
    longint ax, ay, az;
    longint vx, vy, vz;
    longint px, py, pz;
  } nav_result_t;

  typedef struct {
    longint ax, ay, az, qw, qx, qy, qz;
    bit     known;
    longint wx, wy, wz;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid;
  wire in_ready;
  logic signed [AccW-1:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [QuatW-1:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  wire out_valid;
  logic out_ready;
  wire signed [AccW-1:0] out_world_accel_x, out_world_accel_y, out_world_accel_z;
  wire signed [StW-1:0] out_velocity_x, out_velocity_y, out_velocity_z;
  wire signed [StW-1:0] out_position_x, out_position_y, out_position_z;

  imu_dead_reckoning_integrator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_world_accel_x(out_world_accel_x), .out_world_accel_y(out_world_accel_y),
    .out_world_accel_z(out_world_accel_z),
    .out_velocity_x(out_velocity_x), .out_velocity_y(out_velocity_y),
    .out_velocity_z(out_velocity_z),
    .out_position_x(out_position_x), .out_position_y(out_position_y),
    .out_position_z(out_position_z)
  );

  // Shadow registers and integrator state
  longint grav[3];
  longint db_limit, decay, tstep;
  longint vel[3], pos[3];

  nav_result_t nav_q[$];
  int err_count;
  int in_idle_pct, out_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint rnd_sh(longint x, int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Rotate, remove gravity, deadband, integrate; update the shadow state
  function automatic nav_result_t integrate_sample(longint ax, longint ay, longint az,
                                                   longint qw, longint qx, longint qy,
                                                   longint qz);
    nav_result_t r;
    longint v[3], u[3], t[3], s[3], acc[3];
    longint sum, mag;
    v[0] = ax; v[1] = ay; v[2] = az;
    u[0] = qx; u[1] = qy; u[2] = qz;
    t[0] = u[1] * v[2] - u[2] * v[1];
    t[1] = u[2] * v[0] - u[0] * v[2];
    t[2] = u[0] * v[1] - u[1] * v[0];
    s[0] = u[1] * t[2] - u[2] * t[1];
    s[1] = u[2] * t[0] - u[0] * t[2];
    s[2] = u[0] * t[1] - u[1] * t[0];
    for (int i = 0; i < 3; i++) begin
      sum = v[i] * (longint'(1) << 28) + 2 * qw * t[i] + 2 * s[i];
      acc[i] = clamp(rnd_sh(sum, 28) - grav[i], 24);
    end
    for (int i = 0; i < 2; i++) begin
      mag = acc[i] < 0 ? -acc[i] : acc[i];
      if (mag < db_limit) begin
        acc[i] = 0;
        vel[i] = rnd_sh(vel[i] * decay, 16);
      end
    end
    for (int i = 0; i < 3; i++) begin
      vel[i] = clamp(vel[i] + rnd_sh(tstep * acc[i], 16), 32);
      pos[i] = clamp(pos[i] + rnd_sh(tstep * vel[i], 16), 32);
    end
    r.ax = acc[0]; r.ay = acc[1]; r.az = acc[2];
    r.vx = vel[0]; r.vy = vel[1]; r.vz = vel[2];
    r.px = pos[0]; r.py = pos[1]; r.pz = pos[2];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
    err_count++;
  endtask

  // Write one register, tracking its value in the shadow copy
  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegGravX: grav[0] = longint'($signed(value[23:0]));
      RegGravY: grav[1] = longint'($signed(value[23:0]));
      RegGravZ: grav[2] = longint'($signed(value[23:0]));
      RegDbLim: db_limit = longint'(value[22:0]);
      RegDecay: decay = longint'(value[15:0]);
      RegTStep: tstep = longint'(value[15:0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(longint gx, longint gy, longint gz, longint lim, longint dec,
                          longint dt);
    write_reg(RegGravX, gx);
    write_reg(RegGravY, gy);
    write_reg(RegGravZ, gz);
    write_reg(RegDbLim, lim);
    write_reg(RegDecay, dec);
    write_reg(RegTStep, dt);
  endtask

  // Idle at random, then hold the item until accepted
  task automatic send_sample(longint ax, longint ay, longint az, longint qw, longint qx,
                             longint qy, longint qz);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax[23:0]; in_accel_y <= ay[23:0]; in_accel_z <= az[23:0];
    in_quat_w <= qw[15:0]; in_quat_x <= qx[15:0];
    in_quat_y <= qy[15:0]; in_quat_z <= qz[15:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    nav_q.push_back(integrate_sample(ax, ay, az, qw, qx, qy, qz));
  endtask

  // Drop valid and wait for every expected item to come out
  task automatic drain();
    in_valid <= 1'b0;
    while (nav_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic longint rand_acc();
    case ($urandom_range(5))
      0: return longint'($signed(24'($urandom)));
      1: return $urandom_range(1) ? 8388607 : -8388608;
      default: return longint'($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic longint rand_q();
    case ($urandom_range(7))
      0: return longint'($signed(16'($urandom)));
      1: return $urandom_range(1) ? 16384 : -16384;
      default: return longint'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++)
      send_sample(rand_acc(), rand_acc(), rand_acc(), rand_q(), rand_q(), rand_q(), rand_q());
  endtask

  // Receiver: random stall, compare each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (nav_q.size() == 0) begin
          $display("%0t result with nothing expected", $realtime);
          err_count++;
        end else begin
          nav_result_t e;
          e = nav_q.pop_front();
          if (out_world_accel_x !== e.ax[23:0]) report_mismatch("accel_x", out_world_accel_x, e.ax);
          if (out_world_accel_y !== e.ay[23:0]) report_mismatch("accel_y", out_world_accel_y, e.ay);
          if (out_world_accel_z !== e.az[23:0]) report_mismatch("accel_z", out_world_accel_z, e.az);
          if (out_velocity_x !== e.vx[31:0]) report_mismatch("velocity_x", out_velocity_x, e.vx);
          if (out_velocity_y !== e.vy[31:0]) report_mismatch("velocity_y", out_velocity_y, e.vy);
          if (out_velocity_z !== e.vz[31:0]) report_mismatch("velocity_z", out_velocity_z, e.vz);
          if (out_position_x !== e.px[31:0]) report_mismatch("position_x", out_position_x, e.px);
          if (out_position_y !== e.py[31:0]) report_mismatch("position_y", out_position_y, e.py);
          if (out_position_z !== e.pz[31:0]) report_mismatch("position_z", out_position_z, e.pz);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Directed rows; a known row carries its world acceleration
  stim_row_t rows[] = '{
    '{0, 0, 0, 16384, 0, 0, 0, 1, 0, 0, 0},
    '{65536, 0, 0, 16384, 0, 0, 0, 1, 65536, 0, 0},
    '{5000, -5000, 70000, 16384, 0, 0, 0, 1, 0, 0, 70000},
    '{8388607, 8388607, 8388607, 16384, 0, 0, 0, 1, 8388607, 8388607, 8388607},
    '{-8388608, -8388608, -8388608, 16384, 0, 0, 0, 1, -8388608, -8388608, -8388608},
    '{65536, 0, 0, -16384, 0, 0, 0, 1, 65536, 0, 0},
    '{65536, 131072, 0, 0, 0, 0, 16384, 0, 0, 0, 0},
    '{65536, 131072, 196608, 0, 16384, 0, 0, 0, 0, 0, 0},
    '{65536, 131072, 196608, 11585, 11585, 0, 0, 0, 0, 0, 0},
    '{8388607, -8388608, 8388607, -32768, 32767, -32768, 32767, 0, 0, 0, 0},
    '{-8388608, 8388607, -8388608, 32767, -32768, 32767, -32768, 0, 0, 0, 0},
    '{1234567, -7654321, 100, 8192, 8192, 8192, 8192, 0, 0, 0, 0},
    '{300000, 300000, 300000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-100000, 250000, -400000, 10000, -9000, 5000, -7000, 0, 0, 0, 0}
  };

  initial begin
    nav_result_t e;
    longint vel_s[3];
    longint pos_s[3];
    err_count = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    grav = '{0, 0, 0};
    db_limit = 11796; decay = 58982; tstep = 3277;
    vel = '{0, 0, 0};
    pos = '{0, 0, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset registers, no idling
    foreach (rows[i]) begin
      if (rows[i].known) begin
        // Check the typed acceleration on a scratch copy of the state
        vel_s = vel; pos_s = pos;
        e = integrate_sample(rows[i].ax, rows[i].ay, rows[i].az, rows[i].qw, rows[i].qx,
                             rows[i].qy, rows[i].qz);
        if (e.ax != rows[i].wx || e.ay != rows[i].wy || e.az != rows[i].wz) begin
          $display("directed row %0d: predicted acceleration disagrees", i);
          err_count++;
        end
        vel = vel_s; pos = pos_s;
      end
      send_sample(rows[i].ax, rows[i].ay, rows[i].az, rows[i].qw, rows[i].qx, rows[i].qy,
                  rows[i].qz);
    end
    drain();

    // Gravity and extremes of the registers
    set_regs(642252, -300000, 8388607, 0, 0, 65535);
    send_sample(65536, 0, 0, 16384, 0, 0, 0);
    send_sample(-8388608, 8388607, 0, 16384, 0, 0, 0);
    drain();
    set_regs(-8388608, 8388607, -8388608, 8388607, 65535, 0);
    send_sample(1000, 2000, 3000, 16384, 0, 0, 0);
    send_sample(8388607, -8388608, 8388607, 0, 0, 0, 16384);
    drain();
    write_reg(3'd6, 24'h123456);
    write_reg(3'd7, 24'hFFFFFF);

    // Random phases across register settings and idle mixes
    in_idle_pct = 33; out_idle_pct = 67;
    set_regs(0, 0, 642252, 11796, 58982, 3277);
    random_phase(500);
    drain();
    in_idle_pct = 67; out_idle_pct = 33;
    set_regs(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
             longint'($signed(24'($urandom))), $urandom_range(200000),
             $urandom_range(65535), $urandom_range(65535));
    random_phase(500);
    drain();
    in_idle_pct = 0; out_idle_pct = 0;
    set_regs(0, 0, 0, 8388607, 65535, 65535);
    random_phase(250);
    drain();
    set_regs(100, -100, 642252, 0, 32768, 1);
    random_phase(250);
    drain();

    if (err_count == 0) begin
      $display("imu_dead_reckoning_integrator_tb: clean");
    end else begin
      $display("imu_dead_reckoning_integrator_tb: errors");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #20ms;
    $display("imu_dead_reckoning_integrator_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

>>> imu_dead_reckoning_integrator.f
hdl/imu_dr_pkg.sv
hdl/imu_dr_queue.sv
hdl/imu_dr_engine.sv
hdl/imu_dead_reckoning_integrator.sv
dv/imu_dead_reckoning_integrator_tb.sv
